// File: src/tcp_segment_checker_top_macros.svh
// ----------------------------------------------------------------------------
// tcp segment checker assertion macros
// shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous reset is low
// ----------------------------------------------------------------------------
`ifndef TCP_SEGMENT_CHECKER_TOP_MACROS_SVH
`define TCP_SEGMENT_CHECKER_TOP_MACROS_SVH

// antecedent and consequent in the same cycle
`define TSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcp segment checker: same-cycle check failed");

// consequent in the cycle after the antecedent
`define TSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcp segment checker: next-cycle check failed");

`endif

// File: src/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tcp segment checker package
// widths, constants and the per-segment summary passed between stages
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam int HEADER_BYTES = 20;
    localparam int HDR_IDX_W    = 5;
    localparam int CNT_W        = 16;
    localparam int WORD_W       = 16;
    // eight 16-bit words summed at the final beat need three extra bits
    localparam int WIDE_W       = 19;
    localparam int IN_TDATA_W   = 80;
    localparam int OUT_TDATA_W  = 168;

    localparam logic [WORD_W-1:0] SUM_ONES = 16'hFFFF;

    typedef struct packed {
        logic [15:0]       source_port;
        logic [15:0]       dest_port;
        logic [31:0]       seq_number;
        logic [31:0]       ack_number;
        logic [7:0]        flag_bits;
        logic [15:0]       window_value;
        logic [15:0]       checksum_value;
        logic [15:0]       urgent_value;
        logic [15:0]       payload_length;
        logic              long_enough;
        logic [WIDE_W-1:0] wide_sum;
    } t_seg_result;

    typedef struct packed {
        logic [CNT_W-1:0] byte_count;
        logic             wrapped;
    } t_trk_status;

endpackage

// File: src/tcp_segment_checker_top.sv
// ----------------------------------------------------------------------------
// tcp segment checker
// parses the tcp header from a byte stream and verifies the internet checksum
// including the ipv4 pseudo-header, one result beat per segment
// ----------------------------------------------------------------------------
// throughput: one byte beat per cycle, set by the single running-sum adder in the
// tracker, while no final beat waits for room in the mid register; results drain
// from the input register through a mid register and an output register
// reset: synchronous active-low i_rst_n clears the counter, running sum and all
// valid flags; captured header bytes are not cleared
// ----------------------------------------------------------------------------
module tcp_segment_checker_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave side: one segment byte per beat
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] data_byte, [39:8] src_address, [71:40] dst_address, [79:72] proto_number
    input  logic [tsc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tlast,
    // master side: one result per segment
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [15:0] source_port, [31:16] dest_port, [63:32] seq_number,
    // [95:64] ack_number, [103:96] flag_bits, [119:104] window_value,
    // [135:120] checksum_value, [151:136] urgent_value, [167:152] payload_length
    output logic [tsc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [0] accepted
    output logic [0:0]                       m_axis_tuser
);
    import tsc_pkg::*;

    // input register
    logic                  r_i_valid;
    logic [IN_TDATA_W-1:0] r_i_tdata;
    logic                  r_i_last;

    // mid register: summary of a finished segment
    logic                  r_m_valid;
    t_seg_result           r_m_res;

    // output register
    logic                   r_o_valid;
    logic [OUT_TDATA_W-1:0] r_o_tdata;
    logic                   r_o_accepted;

    logic        o_free;
    logic        m_adv;
    logic        m_free;
    logic        i_adv;
    t_seg_result trk_result;
    t_trk_status trk_status;
    logic        fold_accepted;

    // elastic chain: only the final beat of a segment needs room downstream
    assign o_free        = !r_o_valid || m_axis_tready;
    assign m_adv         = r_m_valid && o_free;
    assign m_free        = !r_m_valid || m_adv;
    assign i_adv         = r_i_valid && (!r_i_last || m_free);
    assign s_axis_tready = !r_i_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_i_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_i_tdata <= s_axis_tdata;
            r_i_last  <= s_axis_tlast;
        end
    end

    tsc_seg_track u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (i_adv),
        .i_data_byte    (r_i_tdata[7:0]),
        .i_last         (r_i_last),
        .i_src_address  (r_i_tdata[39:8]),
        .i_dst_address  (r_i_tdata[71:40]),
        .i_proto_number (r_i_tdata[79:72]),
        .o_result       (trk_result),
        .o_status       (trk_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_adv && r_i_last) begin
            r_m_valid <= 1'b1;
        end else if (m_adv) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && r_i_last) begin
            r_m_res <= trk_result;
        end
    end

    // checksum fold and compare between the mid and output registers
    tsc_fold u_fold (
        .i_result   (r_m_res),
        .o_accepted (fold_accepted)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (m_adv) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_adv) begin
            r_o_tdata <= {r_m_res.payload_length, r_m_res.urgent_value,
                          r_m_res.checksum_value, r_m_res.window_value,
                          r_m_res.flag_bits, r_m_res.ack_number,
                          r_m_res.seq_number, r_m_res.dest_port,
                          r_m_res.source_port};
            r_o_accepted <= fold_accepted;
        end
    end

    assign m_axis_tvalid   = r_o_valid;
    assign m_axis_tdata    = r_o_tdata;
    assign m_axis_tuser[0] = r_o_accepted;

`include "tcp_segment_checker_top_macros.svh"

    // a consumed final beat leaves the tracker ready for a new segment
    `TSC_ASSERT_NEXT(a_seg_restart, i_clk, i_rst_n, i_adv && r_i_last, (trk_status.byte_count == '0) && !trk_status.wrapped)
    // a blocked segment summary is held until the output register frees up
    `TSC_ASSERT_NEXT(a_mid_hold, i_clk, i_rst_n, r_m_valid && !o_free, r_m_valid && $stable(r_m_res))
    // a summary leaving the mid register shows up as a result beat
    `TSC_ASSERT_NEXT(a_mid_to_out, i_clk, i_rst_n, m_adv, m_axis_tvalid)

endmodule

// File: src/tsc_seg_track.sv
// ----------------------------------------------------------------------------
// tcp segment tracker
// byte counter, header capture and running ones'-complement sum; builds the
// segment summary with the unfolded pseudo-header total on the final byte
// ----------------------------------------------------------------------------
module tsc_seg_track (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last,
    input  logic [31:0]          i_src_address,
    input  logic [31:0]          i_dst_address,
    input  logic [7:0]           i_proto_number,
    output tsc_pkg::t_seg_result o_result,
    output tsc_pkg::t_trk_status o_status
);
    import tsc_pkg::*;

    logic [CNT_W-1:0]  r_byte_count;
    logic [WORD_W-1:0] r_word_sum;
    logic [7:0]        r_pending;
    logic              r_wrapped;
    logic [7:0]        r_hdr [HEADER_BYTES];

    logic [CNT_W-1:0]  n_byte_count;
    logic [WORD_W-1:0] n_word_sum;
    logic              n_wrapped;
    logic [7:0]        n_hdr [HEADER_BYTES];
    logic [WORD_W-1:0] data_word;
    logic [WORD_W:0]   run_sum;
    logic              capture;
    logic [WIDE_W-1:0] wide_sum;
    logic              long_enough;

    assign n_byte_count = r_byte_count + 16'd1;
    assign n_wrapped    = r_wrapped || (n_byte_count == '0);
    assign capture      = !r_wrapped && (r_byte_count < CNT_W'(HEADER_BYTES));

    // even position opens a word, odd position closes it; odd final byte pads low
    always_comb begin
        if (r_byte_count[0]) begin
            data_word = {r_pending, i_data_byte};
        end else if (i_last) begin
            data_word = {i_data_byte, 8'h00};
        end else begin
            data_word = '0;
        end
    end

    // end-around carry keeps the running sum at 16 bits
    assign run_sum    = {1'b0, r_word_sum} + {1'b0, data_word};
    assign n_word_sum = run_sum[WORD_W-1:0] + WORD_W'(run_sum[WORD_W]);

    always_comb begin
        for (int k = 0; k < HEADER_BYTES; k++) begin
            if (capture && (r_byte_count[HDR_IDX_W-1:0] == HDR_IDX_W'(k))) begin
                n_hdr[k] = i_data_byte;
            end else begin
                n_hdr[k] = r_hdr[k];
            end
        end
    end

    // wide total folded later: same result as an end-around add per word
    assign wide_sum = WIDE_W'(r_word_sum) + WIDE_W'(data_word)
                    + WIDE_W'(i_src_address[31:16]) + WIDE_W'(i_src_address[15:0])
                    + WIDE_W'(i_dst_address[31:16]) + WIDE_W'(i_dst_address[15:0])
                    + WIDE_W'(i_proto_number) + WIDE_W'(n_byte_count);

    assign long_enough = n_wrapped || (n_byte_count >= CNT_W'(HEADER_BYTES));

    always_comb begin
        o_result             = '0;
        o_result.long_enough = long_enough;
        o_result.wide_sum    = wide_sum;
        if (long_enough) begin
            o_result.source_port    = {n_hdr[0], n_hdr[1]};
            o_result.dest_port      = {n_hdr[2], n_hdr[3]};
            o_result.seq_number     = {n_hdr[4], n_hdr[5], n_hdr[6], n_hdr[7]};
            o_result.ack_number     = {n_hdr[8], n_hdr[9], n_hdr[10], n_hdr[11]};
            o_result.flag_bits      = n_hdr[13];
            o_result.window_value   = {n_hdr[14], n_hdr[15]};
            o_result.checksum_value = {n_hdr[16], n_hdr[17]};
            o_result.urgent_value   = {n_hdr[18], n_hdr[19]};
            o_result.payload_length = n_byte_count - CNT_W'(HEADER_BYTES);
        end
    end

    assign o_status.byte_count = r_byte_count;
    assign o_status.wrapped    = r_wrapped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_word_sum   <= '0;
            r_pending    <= '0;
            r_wrapped    <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_byte_count <= '0;
                r_word_sum   <= '0;
                r_pending    <= '0;
                r_wrapped    <= 1'b0;
            end else begin
                r_byte_count <= n_byte_count;
                r_word_sum   <= n_word_sum;
                r_wrapped    <= n_wrapped;
                if (!r_byte_count[0]) begin
                    r_pending <= i_data_byte;
                end
            end
        end
    end

    // header bytes hold their contents across segments
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_hdr <= n_hdr;
        end
    end

endmodule

// File: src/tsc_fold.sv
// ----------------------------------------------------------------------------
// tcp segment checksum fold
// folds the wide pseudo-header total to 16 bits and checks for all ones on a segment holding a full header
// ----------------------------------------------------------------------------
module tsc_fold (
    input  tsc_pkg::t_seg_result i_result,
    output logic                 o_accepted
);
    import tsc_pkg::*;

    logic [WORD_W:0]   fold_one;
    logic [WORD_W-1:0] fold_two;

    // total stays below 2^19, so two folds settle it
    assign fold_one   = {1'b0, i_result.wide_sum[WORD_W-1:0]}
                      + (WORD_W+1)'(i_result.wide_sum[WIDE_W-1:WORD_W]);
    assign fold_two   = fold_one[WORD_W-1:0] + WORD_W'(fold_one[WORD_W]);
    assign o_accepted = i_result.long_enough && (fold_two == SUM_ONES);

endmodule
